### rtl/buffer_frame_clock_manager_defines.svh
// Assertion macros for the frame manager.
`ifndef BUFFER_FRAME_CLOCK_MANAGER_DEFINES_SVH
`define BUFFER_FRAME_CLOCK_MANAGER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BFCM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked at every clock edge, reset included.
`define BFCM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/bfcm_pkg.sv
// ----------------------------------------------------------------------------
// bfcm_pkg
// Types and constants shared by the frame manager files.
// ----------------------------------------------------------------------------
package bfcm_pkg;
    localparam int NUM_FRAMES = 16;
    localparam int FW = $clog2(NUM_FRAMES);
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int MAX_ACTIVE = (NUM_FRAMES < 16) ? NUM_FRAMES : 16;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_UNPIN   = 3'd1;
    localparam logic [2:0] OP_ALLOC   = 3'd2;
    localparam logic [2:0] OP_DISPOSE = 3'd3;
    localparam logic [2:0] OP_FLUSH   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ALL_PIN  = 2'd1;
    localparam logic [1:0] ST_PIN_ERR  = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] file_id;
        logic [31:0] page_no;
        logic        dirty;
    } t_req;

    typedef struct packed {
        logic [3:0]  frame_index;
        logic        hit;
        logic        read_needed;
        logic        writeback;
        logic [15:0] wb_file_id;
        logic [31:0] wb_page_no;
        logic [1:0]  status;
        logic        last;
    } t_rsp;
endpackage

### rtl/bfcm_if.sv
// ----------------------------------------------------------------------------
// bfcm_req_if / bfcm_rsp_if
// Valid/ready channels for request and result beats.
// ----------------------------------------------------------------------------
interface bfcm_req_if;
    logic             valid;
    logic             ready;
    bfcm_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bfcm_rsp_if;
    logic             valid;
    logic             ready;
    bfcm_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/buffer_frame_clock_manager.sv
// ----------------------------------------------------------------------------
// buffer_frame_clock_manager
// Page-frame table with clock replacement and pin counts.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  i_req     in   opcode, file_id, page_no, dirty
//  o_rsp     out  frame_index, hit, read_needed, writeback, wb tag, status, last
//  cfg       in   i_cfg_we / i_cfg_wdata : frames_in_use
// Lookup walks the frames one per cycle through one tag comparator.
// A clock scan examines one frame per cycle, at most 2n frames, and then fails.
// In a flush, each beat after the first revisits its frame once.
// The receiver can hold off a beat; the manager then waits with the beat held.
// Reset is synchronous; frame state resets through its flag bits.
`include "buffer_frame_clock_manager_defines.svh"
module buffer_frame_clock_manager (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [4:0]          i_cfg_wdata,
    bfcm_req_if.sink            i_req,
    bfcm_rsp_if.source          o_rsp
);
    localparam int FW = bfcm_pkg::FW;
    localparam int CW = bfcm_pkg::CW;
    localparam int NF = bfcm_pkg::NUM_FRAMES;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_FIND = 6'b000010,
        S_DO   = 6'b000100,
        S_SCAN = 6'b001000,
        S_FLSH = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state             r_state;
    logic [4:0]         r_fiu;
    logic [CW-1:0]      r_n;
    logic [FW-1:0]      r_hand;
    logic [FW-1:0]      r_idx;
    logic [CW:0]        r_cnt;
    logic               r_found;
    logic [FW-1:0]      r_fidx;
    logic               r_any;
    logic               r_flush_done;
    bfcm_pkg::t_req     r_req;
    bfcm_pkg::t_rsp     r_rsp;
    logic [NF-1:0]      r_valid, r_dirty, r_ref;
    logic [7:0]         r_pins [NF];
    logic [15:0]        r_ftag [NF];
    logic [31:0]        r_ptag [NF];

    // Active frame count, clamped.
    logic [CW-1:0] n_n;
    always_comb begin
        if (r_fiu == 5'd0) n_n = CW'(1);
        else if (32'(r_fiu) > bfcm_pkg::MAX_ACTIVE) n_n = CW'(bfcm_pkg::MAX_ACTIVE);
        else n_n = CW'(r_fiu);
    end

    logic [FW-1:0] w_hand_next;
    assign w_hand_next = (CW'(r_hand) + CW'(1) >= r_n) ? '0 : r_hand + FW'(1);
    logic w_idx_last;
    assign w_idx_last = (CW'(r_idx) + CW'(1) >= r_n);

    // Miss on read or allocate goes to the clock scan.
    logic w_need_scan;
    assign w_need_scan = !r_found && (r_req.opcode == bfcm_pkg::OP_READ ||
                                      r_req.opcode == bfcm_pkg::OP_ALLOC);

    // Shared tag comparator at r_idx.
    logic w_file_eq, w_tag_eq;
    assign w_file_eq = r_valid[r_idx] && (r_ftag[r_idx] == r_req.file_id);
    assign w_tag_eq  = w_file_eq && (r_ptag[r_idx] == r_req.page_no);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = r_rsp;

    function automatic bfcm_pkg::t_rsp mk(logic [3:0] f, logic h, logic rd, logic [1:0] st);
        bfcm_pkg::t_rsp r;
        r = '0;
        r.frame_index = f; r.hit = h; r.read_needed = rd; r.status = st; r.last = 1'b1;
        return r;
    endfunction

    // Adds the writeback tag when needed and sets last.
    function automatic bfcm_pkg::t_rsp mk_wb(bfcm_pkg::t_rsp b, logic wb, logic [15:0] wf,
                                             logic [31:0] wp, logic lst);
        bfcm_pkg::t_rsp r;
        r = b;
        if (wb) begin
            r.writeback  = 1'b1;
            r.wb_file_id = wf;
            r.wb_page_no = wp;
        end
        r.last = lst;
        return r;
    endfunction

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fiu   <= 5'd16;
            r_n     <= '0;
            r_hand  <= FW'(bfcm_pkg::MAX_ACTIVE - 1);
            r_valid <= '0;
            r_dirty <= '0;
            r_ref   <= '0;
            r_flush_done <= 1'b0;
            for (int i = 0; i < NF; i++) r_pins[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fiu <= i_cfg_wdata;
                if (i_cfg_wdata == 5'd0) r_hand <= '0;
                else if (32'(i_cfg_wdata) > bfcm_pkg::MAX_ACTIVE)
                    r_hand <= FW'(bfcm_pkg::MAX_ACTIVE - 1);
                else r_hand <= FW'(i_cfg_wdata - 5'd1);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req   <= i_req.data;
                        r_n     <= n_n;
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_any   <= 1'b0;
                        r_flush_done <= 1'b0;
                        r_state <= (i_req.data.opcode == bfcm_pkg::OP_FLUSH) ? S_FLSH : S_FIND;
                    end
                end
                S_FIND: begin
                    if (w_tag_eq && !r_found) begin
                        r_found <= 1'b1;
                        r_fidx  <= r_idx;
                    end
                    if (w_idx_last) r_state <= S_DO;
                    else r_idx <= r_idx + FW'(1);
                end
                S_DO: begin
                    r_state <= w_need_scan ? S_SCAN : S_OUT;
                    r_cnt   <= '0;
                    unique case (r_req.opcode)
                        bfcm_pkg::OP_READ: begin
                            if (!r_found) begin
                                if (CW'(r_hand) >= r_n) r_hand <= '0;
                            end else if (r_pins[r_fidx] == 8'hFF) begin
                                r_rsp <= mk(4'(r_fidx), 1'b1, 1'b0, bfcm_pkg::ST_PIN_ERR);
                            end else begin
                                r_ref[r_fidx]  <= 1'b1;
                                r_pins[r_fidx] <= r_pins[r_fidx] + 8'd1;
                                r_rsp <= mk(4'(r_fidx), 1'b1, 1'b0, bfcm_pkg::ST_OK);
                            end
                        end
                        bfcm_pkg::OP_UNPIN: begin
                            if (!r_found) r_rsp <= mk(4'd0, 1'b0, 1'b0, bfcm_pkg::ST_NOTFOUND);
                            else if (r_pins[r_fidx] == 8'd0)
                                r_rsp <= mk(4'(r_fidx), 1'b1, 1'b0, bfcm_pkg::ST_PIN_ERR);
                            else begin
                                r_pins[r_fidx] <= r_pins[r_fidx] - 8'd1;
                                if (r_req.dirty) r_dirty[r_fidx] <= 1'b1;
                                r_rsp <= mk(4'(r_fidx), 1'b1, 1'b0, bfcm_pkg::ST_OK);
                            end
                        end
                        bfcm_pkg::OP_ALLOC: begin
                            if (r_found)
                                r_rsp <= mk(4'(r_fidx), 1'b1, 1'b0, bfcm_pkg::ST_NOTFOUND);
                            else if (CW'(r_hand) >= r_n) r_hand <= '0;
                        end
                        bfcm_pkg::OP_DISPOSE: begin
                            if (!r_found) r_rsp <= mk(4'd0, 1'b0, 1'b0, bfcm_pkg::ST_NOTFOUND);
                            else begin
                                r_valid[r_fidx] <= 1'b0;
                                r_dirty[r_fidx] <= 1'b0;
                                r_ref[r_fidx]   <= 1'b0;
                                r_pins[r_fidx]  <= 8'd0;
                                r_rsp <= mk(4'(r_fidx), 1'b1, 1'b0, bfcm_pkg::ST_OK);
                            end
                        end
                        default: r_rsp <= mk(4'd0, 1'b0, 1'b0, bfcm_pkg::ST_NOTFOUND);
                    endcase
                    r_flush_done <= 1'b1;
                end
                // One frame examined per cycle at the hand.
                S_SCAN: begin
                    r_cnt <= r_cnt + (CW+1)'(1);
                    if (r_cnt >= (CW+1)'({r_n, 1'b0})) begin
                        r_rsp   <= mk(4'd0, 1'b0, 1'b0, bfcm_pkg::ST_ALL_PIN);
                        r_state <= S_OUT;
                    end else if (r_valid[r_hand] && r_ref[r_hand]) begin
                        r_ref[r_hand] <= 1'b0;
                        r_hand <= w_hand_next;
                    end else if (r_valid[r_hand] && r_pins[r_hand] != 8'd0) begin
                        r_hand <= w_hand_next;
                    end else begin
                        r_rsp <= mk_wb(mk(4'(r_hand), 1'b0,
                                          r_req.opcode == bfcm_pkg::OP_READ, bfcm_pkg::ST_OK),
                                       r_valid[r_hand] && r_dirty[r_hand],
                                       r_ftag[r_hand], r_ptag[r_hand], 1'b1);
                        r_valid[r_hand] <= 1'b1;
                        r_dirty[r_hand] <= 1'b0;
                        r_ref[r_hand]   <= 1'b1;
                        r_pins[r_hand]  <= 8'd1;
                        r_ftag[r_hand]  <= r_req.file_id;
                        r_ptag[r_hand]  <= r_req.page_no;
                        r_state <= S_OUT;
                    end
                end
                // Flush walks frames in order; a matched beat is held in r_rsp
                // until the next match or the end tells whether it is last.
                S_FLSH: begin
                    if (w_file_eq && r_any) begin
                        // send the held beat, then revisit this frame
                        r_state <= S_OUT;
                    end else if (w_file_eq && r_pins[r_idx] != 8'd0) begin
                        r_rsp <= mk(4'(r_idx), 1'b1, 1'b0, bfcm_pkg::ST_NOTFOUND);
                        r_flush_done <= 1'b1;
                        r_state <= S_OUT;
                    end else if (w_file_eq) begin
                        r_rsp <= mk_wb(mk(4'(r_idx), 1'b1, 1'b0, bfcm_pkg::ST_OK),
                                       r_dirty[r_idx], r_ftag[r_idx], r_ptag[r_idx],
                                       w_idx_last);
                        r_any <= 1'b1;
                        r_valid[r_idx] <= 1'b0;
                        r_dirty[r_idx] <= 1'b0;
                        r_ref[r_idx]   <= 1'b0;
                        if (w_idx_last) begin
                            r_flush_done <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_idx <= r_idx + FW'(1);
                        end
                    end else if (w_idx_last) begin
                        r_flush_done <= 1'b1;
                        r_state <= S_OUT;
                        if (r_any) r_rsp.last <= 1'b1;
                        else r_rsp <= mk(4'd0, 1'b0, 1'b0, bfcm_pkg::ST_NOTFOUND);
                    end else begin
                        r_idx <= r_idx + FW'(1);
                    end
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        if (r_flush_done) r_state <= S_IDLE;
                        else begin
                            r_any   <= 1'b0;
                            r_state <= S_FLSH;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Flush needs a lookahead so the final match carries last: handled by
    // deferring each matched beat until the next match or the end is known.
    `BFCM_ASSERT(a_busy_not_ready, i_clk, i_rst_n, (r_state != S_IDLE) |-> !i_req.ready, "ready while busy")
    `BFCM_ASSERT(a_out_hold, i_clk, i_rst_n, (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(r_rsp)), "result dropped")
    `BFCM_ASSERT(a_hand_range, i_clk, i_rst_n, (r_state == S_SCAN) |-> (CW'(r_hand) < r_n), "hand out of range")
endmodule

### tb/tb_buffer_frame_clock_manager.sv
// ----------------------------------------------------------------------------
// tb_buffer_frame_clock_manager
// Self-checking bench for the frame manager. Sends request beats, predicts
// each result beat from a behavioral frame table with clock replacement and
// pin counts, and compares every field. It covers directed cases, several
// frame counts and a random mix with stalls on both sides.
// ----------------------------------------------------------------------------
module tb_buffer_frame_clock_manager;
    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 3 * 16 + 16;
    localparam int NF = bfcm_pkg::NUM_FRAMES;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [4:0] i_cfg_wdata;

    bfcm_req_if req_if ();
    bfcm_rsp_if rsp_if ();

    buffer_frame_clock_manager u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if.sink),
        .o_rsp       (rsp_if.source)
    );

    always #2 i_clk = ~i_clk;

    // Frame table mirror
    logic        frm_valid [NF];
    logic        frm_dirty [NF];
    logic        frm_ref   [NF];
    logic [7:0]  frm_pins  [NF];
    logic [15:0] frm_file  [NF];
    logic [31:0] frm_page  [NF];
    logic [4:0]  frames_reg;
    int          hand;

    bfcm_pkg::t_rsp pending_results[$];
    int   errors = 0;
    int   cycles = 0;
    bit   idle_on = 1'b1;
    int   hold_request = 0;

    logic [15:0] file_pool [4];
    logic [31:0] page_pool [6];

    function automatic int active_count();
        int n;
        n = int'(frames_reg);
        if (n < 1) n = 1;
        if (n > bfcm_pkg::MAX_ACTIVE) n = bfcm_pkg::MAX_ACTIVE;
        return n;
    endfunction

    function automatic bfcm_pkg::t_rsp blank_rsp(int frame, bit hit, logic [1:0] st);
        bfcm_pkg::t_rsp r;
        r = '0;
        r.frame_index = frame[3:0];
        r.hit = hit;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic int lookup(logic [15:0] f, logic [31:0] p);
        for (int i = 0; i < active_count(); i++)
            if (frm_valid[i] && frm_file[i] == f && frm_page[i] == p) return i;
        return -1;
    endfunction

    function automatic void clear_entry(int i);
        frm_valid[i] = 0;
        frm_dirty[i] = 0;
        frm_ref[i] = 0;
        frm_pins[i] = 0;
    endfunction

    // Second-chance sweep from the hand; -1 when every frame is pinned
    function automatic int pick_victim();
        int n;
        int h;
        n = active_count();
        if (hand >= n) hand = 0;
        for (int k = 0; k < 2 * n; k++) begin
            h = hand;
            if (!frm_valid[h]) return h;
            if (frm_ref[h]) begin
                frm_ref[h] = 0;
                hand = (h + 1) % n;
            end else if (frm_pins[h] != 0) begin
                hand = (h + 1) % n;
            end else begin
                return h;
            end
        end
        return -1;
    endfunction

    function automatic bfcm_pkg::t_rsp load_frame(logic [15:0] f, logic [31:0] p, bit rd);
        bfcm_pkg::t_rsp r;
        int v;
        v = pick_victim();
        if (v < 0) return blank_rsp(0, 1'b0, bfcm_pkg::ST_ALL_PIN);
        r = blank_rsp(v, 1'b0, bfcm_pkg::ST_OK);
        r.read_needed = rd;
        if (frm_valid[v] && frm_dirty[v]) begin
            r.writeback = 1'b1;
            r.wb_file_id = frm_file[v];
            r.wb_page_no = frm_page[v];
        end
        frm_valid[v] = 1;
        frm_dirty[v] = 0;
        frm_ref[v] = 1;
        frm_pins[v] = 1;
        frm_file[v] = f;
        frm_page[v] = p;
        return r;
    endfunction

    // Apply one request to the mirror and queue the beats it produces
    function automatic void predict_frame_request(bfcm_pkg::t_req q);
        bfcm_pkg::t_rsp r;
        bfcm_pkg::t_rsp burst[$];
        int   f;
        f = lookup(q.file_id, q.page_no);
        case (q.opcode)
            bfcm_pkg::OP_READ: begin
                if (f < 0) burst.push_back(load_frame(q.file_id, q.page_no, 1'b1));
                else if (frm_pins[f] == 8'd255)
                    burst.push_back(blank_rsp(f, 1'b1, bfcm_pkg::ST_PIN_ERR));
                else begin
                    frm_ref[f] = 1;
                    frm_pins[f]++;
                    burst.push_back(blank_rsp(f, 1'b1, bfcm_pkg::ST_OK));
                end
            end
            bfcm_pkg::OP_UNPIN: begin
                if (f < 0) burst.push_back(blank_rsp(0, 1'b0, bfcm_pkg::ST_NOTFOUND));
                else if (frm_pins[f] == 0)
                    burst.push_back(blank_rsp(f, 1'b1, bfcm_pkg::ST_PIN_ERR));
                else begin
                    frm_pins[f]--;
                    if (q.dirty) frm_dirty[f] = 1;
                    burst.push_back(blank_rsp(f, 1'b1, bfcm_pkg::ST_OK));
                end
            end
            bfcm_pkg::OP_ALLOC: begin
                if (f >= 0) burst.push_back(blank_rsp(f, 1'b1, bfcm_pkg::ST_NOTFOUND));
                else burst.push_back(load_frame(q.file_id, q.page_no, 1'b0));
            end
            bfcm_pkg::OP_DISPOSE: begin
                if (f < 0) burst.push_back(blank_rsp(0, 1'b0, bfcm_pkg::ST_NOTFOUND));
                else begin
                    clear_entry(f);
                    burst.push_back(blank_rsp(f, 1'b1, bfcm_pkg::ST_OK));
                end
            end
            bfcm_pkg::OP_FLUSH: begin
                for (int i = 0; i < active_count(); i++) begin
                    if (!frm_valid[i] || frm_file[i] != q.file_id) continue;
                    if (frm_pins[i] != 0) begin
                        burst.push_back(blank_rsp(i, 1'b1, bfcm_pkg::ST_NOTFOUND));
                        break;
                    end
                    r = blank_rsp(i, 1'b1, bfcm_pkg::ST_OK);
                    if (frm_dirty[i]) begin
                        r.writeback = 1'b1;
                        r.wb_file_id = frm_file[i];
                        r.wb_page_no = frm_page[i];
                    end
                    burst.push_back(r);
                    clear_entry(i);
                end
                if (burst.size() == 0)
                    burst.push_back(blank_rsp(0, 1'b0, bfcm_pkg::ST_NOTFOUND));
            end
            default: burst.push_back(blank_rsp(0, 1'b0, bfcm_pkg::ST_NOTFOUND));
        endcase
        foreach (burst[i]) begin
            burst[i].last = (i == burst.size() - 1);
            pending_results.push_back(burst[i]);
        end
    endfunction

    // Send one request beat, with an optional random gap before it.
    // Valid stays up after the accept; the next call or a drain replaces it.
    task automatic send_request(logic [2:0] op, logic [15:0] f, logic [31:0] p, bit d);
        bfcm_pkg::t_req q;
        int   gap;
        q.opcode = op;
        q.file_id = f;
        q.page_no = p;
        q.dirty = d;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= q;
        do @(posedge i_clk); while (!req_if.ready);
        predict_frame_request(q);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frames(logic [4:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        frames_reg = v;
        hand = active_count() - 1;
    endtask

    // Receiver: random stall bursts, plus a long hold on request
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_request > 0) begin
            hold_request = hold_request - 1;
            rsp_if.ready <= 1'b0;
        end else if (!idle_on) begin
            rsp_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_if.ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        bfcm_pkg::t_rsp e;
        bfcm_pkg::t_rsp a;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            a = rsp_if.data;
            if (pending_results.size() == 0) begin
                $error("unexpected result beat frame_index=%0d", a.frame_index);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (a.frame_index !== e.frame_index) begin
                    $error("frame_index exp %0d got %0d", e.frame_index, a.frame_index);
                    errors++;
                end
                if (a.hit !== e.hit) begin
                    $error("hit exp %0d got %0d", e.hit, a.hit);
                    errors++;
                end
                if (a.read_needed !== e.read_needed) begin
                    $error("read_needed exp %0d got %0d", e.read_needed, a.read_needed);
                    errors++;
                end
                if (a.writeback !== e.writeback) begin
                    $error("writeback exp %0d got %0d", e.writeback, a.writeback);
                    errors++;
                end
                if (a.wb_file_id !== e.wb_file_id) begin
                    $error("wb_file_id exp %h got %h", e.wb_file_id, a.wb_file_id);
                    errors++;
                end
                if (a.wb_page_no !== e.wb_page_no) begin
                    $error("wb_page_no exp %h got %h", e.wb_page_no, a.wb_page_no);
                    errors++;
                end
                if (a.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, a.status);
                    errors++;
                end
                if (a.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, a.last);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL buffer_frame_clock_manager");
            $finish;
        end
    end

    // Extremes, every opcode, eviction with writeback, all pinned, flush cases
    task automatic test_directed();
        write_frames(5'd2);
        send_request(bfcm_pkg::OP_READ, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
        send_request(bfcm_pkg::OP_READ, 16'h0000, 32'h0000_0000, 1'b0);
        send_request(bfcm_pkg::OP_READ, 16'h1234, 32'h5, 1'b0);         // every frame pinned
        send_request(bfcm_pkg::OP_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 1'b0); // resident
        send_request(bfcm_pkg::OP_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        send_request(bfcm_pkg::OP_UNPIN, 16'hFFFF, 32'hFFFF_FFFF, 1'b1); // already unpinned
        send_request(bfcm_pkg::OP_UNPIN, 16'h7777, 32'h9, 1'b0);         // not resident
        send_request(bfcm_pkg::OP_ALLOC, 16'h00AA, 32'h8000_0000, 1'b0); // evicts dirty page
        send_request(bfcm_pkg::OP_FLUSH, 16'h0000, 32'h0, 1'b0);         // pinned, stops
        send_request(bfcm_pkg::OP_UNPIN, 16'h0000, 32'h0, 1'b1);
        send_request(bfcm_pkg::OP_FLUSH, 16'h0000, 32'h0, 1'b0);
        send_request(bfcm_pkg::OP_FLUSH, 16'h4321, 32'h0, 1'b0);         // no match
        send_request(bfcm_pkg::OP_DISPOSE, 16'h00AA, 32'h8000_0000, 1'b0);
        send_request(bfcm_pkg::OP_DISPOSE, 16'h00AA, 32'h8000_0000, 1'b0);
        send_request(3'd5, 16'h0, 32'h0, 1'b0);
        send_request(3'd6, 16'h0, 32'h0, 1'b1);
        send_request(3'd7, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        // multi-beat flush, dirty and clean frames of one file
        write_frames(5'd4);
        send_request(bfcm_pkg::OP_READ, 16'h0055, 32'h1, 1'b0);
        send_request(bfcm_pkg::OP_READ, 16'h0055, 32'h2, 1'b0);
        send_request(bfcm_pkg::OP_UNPIN, 16'h0055, 32'h1, 1'b1);
        send_request(bfcm_pkg::OP_UNPIN, 16'h0055, 32'h2, 1'b0);
        send_request(bfcm_pkg::OP_FLUSH, 16'h0055, 32'h0, 1'b0);
    endtask

    task automatic random_item();
        logic [2:0]  op;
        logic [15:0] f;
        logic [31:0] p;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 40) op = bfcm_pkg::OP_READ;
        else if (sel < 70) op = bfcm_pkg::OP_UNPIN;
        else if (sel < 82) op = bfcm_pkg::OP_ALLOC;
        else if (sel < 90) op = bfcm_pkg::OP_DISPOSE;
        else if (sel < 97) op = bfcm_pkg::OP_FLUSH;
        else op = 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) == 0) begin
            f = 16'($urandom);
            p = $urandom;
        end else begin
            f = file_pool[$urandom_range(0, 3)];
            p = page_pool[$urandom_range(0, 5)];
        end
        send_request(op, f, p, 1'($urandom_range(0, 1)));
    endtask

    // Frame-count sweep, clamped values included, random traffic each phase
    task automatic test_frame_counts();
        logic [4:0] counts [6] = '{5'd0, 5'd31, 5'd3, 5'd16, 5'd7, 5'd1};
        foreach (counts[i]) begin
            write_frames(counts[i]);
            repeat (22) random_item();
        end
    endtask

    // Long receiver hold while requests keep coming, then a full drain pause
    task automatic test_backpressure();
        write_frames(5'd16);
        hold_request = 600;
        repeat (20) random_item();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) random_item();
    endtask

    task automatic test_no_idle();
        write_frames(5'd8);
        idle_on = 1'b0;
        repeat (40) random_item();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        for (int i = 0; i < NF; i++) begin
            clear_entry(i);
            frm_file[i] = '0;
            frm_page[i] = '0;
        end
        frames_reg = 5'd16;
        hand = active_count() - 1;
        file_pool = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000};
        file_pool[2] = 16'($urandom);
        file_pool[3] = 16'($urandom);
        page_pool = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0};
        for (int i = 2; i < 6; i++) page_pool[i] = $urandom;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_frame_counts();
        test_backpressure();
        test_no_idle();

        wait_drained();
        if (errors == 0) begin
            $display("PASS buffer_frame_clock_manager");
        end else begin
            $display("FAIL buffer_frame_clock_manager");
        end
        $finish;
    end
endmodule

### buffer_frame_clock_manager.f
+incdir+rtl
rtl/bfcm_pkg.sv
rtl/bfcm_if.sv
rtl/buffer_frame_clock_manager.sv
tb/tb_buffer_frame_clock_manager.sv
